// ===== design/c6502x_pkg.sv =====
// c6502x_pkg: word types, command and opcode codes, reset values and decode helpers
// for the 6502 subset executor; no dependencies
package c6502x_pkg;

  localparam int unsigned MEM_BYTES_DEF = 65536;

  // commands
  localparam logic [1:0] CMD_EXEC = 2'd0;
  localparam logic [1:0] CMD_WR   = 2'd1;
  localparam logic [1:0] CMD_RD   = 2'd2;

  // supported opcodes
  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STA_ABX = 8'h9D;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_CMP_ABX = 8'hDD;
  localparam logic [7:0] OP_BPL     = 8'h10;
  localparam logic [7:0] OP_BMI     = 8'h30;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_CLD     = 8'hD8;

  // status bits
  localparam int unsigned P_N = 7;
  localparam int unsigned P_B = 4;
  localparam int unsigned P_D = 3;
  localparam int unsigned P_I = 2;
  localparam int unsigned P_Z = 1;
  localparam int unsigned P_C = 0;

  localparam logic [7:0]  SP_RESET   = 8'hFD;
  localparam logic [7:0]  P_RESET    = 8'h24;
  localparam logic [7:0]  P_PUSH_SET = 8'h30;
  localparam logic [7:0]  STACK_PAGE = 8'h01;
  localparam logic [15:0] VEC_BRK    = 16'hFFFE;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  opcode;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [15:0] next_address;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
  } in_word_t;

  typedef struct packed {
    logic [15:0] program_counter;
    logic [7:0]  accumulator;
    logic [7:0]  index_x;
    logic [7:0]  stack_pointer;
    logic [7:0]  status_byte;
    logic [7:0]  read_data;
    logic        unimplemented;
  } out_word_t;

  function automatic logic is_nop(input logic [7:0] op);
    logic r;
    begin
      case (op)
        8'h04, 8'h0C, 8'h14, 8'h1A, 8'h1C, 8'h34, 8'h3A, 8'h3C, 8'h44, 8'h54,
        8'h5A, 8'h5C, 8'h64, 8'h74, 8'h7A, 8'h7C, 8'h80, 8'h82, 8'h89, 8'hC2,
        8'hD4, 8'hDA, 8'hDC, 8'hE2, 8'hEA, 8'hF4, 8'hFA, 8'hFC: r = 1'b1;
        default: r = 1'b0;
      endcase
      return r;
    end
  endfunction

  // update N and Z from a result byte
  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    begin
      r = p;
      r[P_N] = v[7];
      r[P_Z] = (v == 8'd0);
      return r;
    end
  endfunction

endpackage

// ===== design/cpu6502_subset_executor_core.sv =====
// cpu6502_subset_executor_core: 6502 subset sequencer around one single-port byte memory
// depends on c6502x_pkg
//
//  channel | ports                              | word
//  in      | in_valid, in_ready, in_data        | in_word_t: command and instruction bytes
//  out     | out_valid, out_ready, out_data     | out_word_t: registers after the command
//
// one memory port, read data registered and there in the cycle after the address;
// writes, STA and register-only ops pass S_EXEC and S_DONE, reads, LDA abs, CMP add
// S_RD_WAIT; JSR adds two pushes, BRK three pushes and two vector reads in turn.
// rst_n resets A, X, SP, PC and P; memory contents are undefined until written.
// a finished word sits in the output register; the next item is taken while it waits,
// and that item only stalls at its own finish if the first word is still not taken.
module cpu6502_subset_executor_core #(
  parameter int unsigned MEM_BYTES = c6502x_pkg::MEM_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  c6502x_pkg::in_word_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output c6502x_pkg::out_word_t out_data
);
  import c6502x_pkg::*;

  localparam int unsigned AW       = $clog2(MEM_BYTES);
  localparam bit          MEM_POW2 = ((MEM_BYTES & (MEM_BYTES - 1)) == 0);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_RD_WAIT, S_DONE} state_t;

  // offset of each 512-byte block of the address space once folded into the memory
  function automatic logic [127:0][15:0] fold_table();
    logic [127:0][15:0] t;
    begin
      for (int h = 0; h < 128; h++) t[h] = 16'((h * 512) % MEM_BYTES);
      return t;
    end
  endfunction

  localparam logic [127:0][15:0] HI_FOLD = fold_table();

  // fold a 16-bit address into the memory: table for the upper bits, then one
  // compare and subtract since the sum stays below twice MEM_BYTES
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [16:0] r;
    begin
      if (MEM_POW2) return a[AW-1:0];
      r = {1'b0, HI_FOLD[a[15:9]]} + {8'd0, a[8:0]};
      if (r >= 17'(MEM_BYTES)) r = r - 17'(MEM_BYTES);
      return r[AW-1:0];
    end
  endfunction

  state_t     state_r, state_nxt;
  in_word_t   item_r;
  logic [15:0] addr_r;
  logic [2:0] step_r, step_nxt;
  logic [7:0] a_r, a_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic [7:0] p_r, p_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0] rdat_r, rdat_nxt;
  logic [7:0] vec_lo_r, vec_lo_nxt;
  out_word_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic [7:0] mem_r [MEM_BYTES];
  logic [7:0] mem_q_r;
  logic       mem_we;
  logic [15:0] mem_a16;
  logic [7:0] mem_wd;
  logic [AW-1:0] mem_idx;

  logic       accept;
  logic [15:0] abs_addr;
  logic [15:0] ret_addr;
  logic [15:0] br_target;
  logic [7:0] diff;
  logic       taken;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign abs_addr  = {in_data.operand_high, in_data.operand_low};
  assign ret_addr  = (item_r.opcode == OP_BRK) ? item_r.next_address + 16'd1
                                               : item_r.next_address - 16'd1;
  assign br_target = item_r.next_address + {{8{item_r.operand_low[7]}}, item_r.operand_low};
  assign diff      = a_r - rdat_r;
  assign mem_idx   = wrap_addr(mem_a16);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    a_nxt         = a_r;
    x_nxt         = x_r;
    sp_nxt        = sp_r;
    p_nxt         = p_r;
    pc_nxt        = pc_r;
    rdat_nxt      = rdat_r;
    vec_lo_nxt    = vec_lo_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_a16       = addr_r;
    mem_wd        = a_r;
    taken         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
          step_nxt  = 3'd0;
        end
      end

      S_EXEC: begin
        state_nxt = S_DONE;
        case (item_r.command)
          CMD_WR: begin
            mem_we = 1'b1;
            mem_wd = item_r.mem_data;
          end
          CMD_RD: state_nxt = S_RD_WAIT;
          CMD_EXEC: begin
            case (item_r.opcode)
              OP_LDA_ABS, OP_LDA_ABX, OP_CMP_ABX: state_nxt = S_RD_WAIT;
              OP_STA_ABS, OP_STA_ABX: mem_we = 1'b1;
              OP_JSR, OP_BRK: begin
                state_nxt = S_EXEC;
                step_nxt  = step_r + 3'd1;
                case (step_r)
                  3'd0, 3'd1, 3'd2: begin
                    mem_we  = 1'b1;
                    mem_a16 = {STACK_PAGE, sp_r};
                    sp_nxt  = sp_r - 8'd1;
                    if (step_r == 3'd0) begin
                      mem_wd = ret_addr[15:8];
                    end else if (step_r == 3'd1) begin
                      mem_wd = ret_addr[7:0];
                      if (item_r.opcode == OP_JSR) state_nxt = S_DONE;
                    end else begin
                      mem_wd = p_r | P_PUSH_SET;
                    end
                  end
                  3'd3: mem_a16 = VEC_BRK;
                  default: begin
                    // low vector byte is out of the memory now
                    mem_a16    = VEC_BRK + 16'd1;
                    vec_lo_nxt = mem_q_r;
                    state_nxt  = S_RD_WAIT;
                  end
                endcase
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end

      S_RD_WAIT: begin
        rdat_nxt  = mem_q_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.read_data     = 8'd0;
          out_nxt.unimplemented = 1'b0;
          if (item_r.command == CMD_RD) out_nxt.read_data = rdat_r;
          if (item_r.command == CMD_EXEC) begin
            pc_nxt = item_r.next_address;
            case (item_r.opcode)
              OP_BRK: begin
                p_nxt[P_B] = 1'b1;
                p_nxt[P_I] = 1'b1;
                pc_nxt     = {rdat_r, vec_lo_r};
              end
              OP_LDA_IMM: begin
                a_nxt = item_r.operand_low;
                p_nxt = set_nz(p_r, item_r.operand_low);
              end
              OP_LDA_ABS, OP_LDA_ABX: begin
                a_nxt = rdat_r;
                p_nxt = set_nz(p_r, rdat_r);
              end
              OP_LDX_IMM: begin
                x_nxt = item_r.operand_low;
                p_nxt = set_nz(p_r, item_r.operand_low);
              end
              OP_TXS: sp_nxt = x_r;
              OP_TXA: begin
                a_nxt = x_r;
                p_nxt = set_nz(p_r, x_r);
              end
              OP_INX: begin
                x_nxt = x_r + 8'd1;
                p_nxt = set_nz(p_r, x_r + 8'd1);
              end
              OP_DEX: begin
                x_nxt = x_r - 8'd1;
                p_nxt = set_nz(p_r, x_r - 8'd1);
              end
              OP_CMP_ABX: begin
                p_nxt      = set_nz(p_r, diff);
                p_nxt[P_C] = (a_r >= rdat_r);
              end
              OP_BPL: taken = !p_r[P_N];
              OP_BMI: taken = p_r[P_N];
              OP_BNE: taken = !p_r[P_Z];
              OP_JSR: pc_nxt = {item_r.operand_high, item_r.operand_low};
              OP_SEI: p_nxt[P_I] = 1'b1;
              OP_CLD: p_nxt[P_D] = 1'b0;
              OP_STA_ABS, OP_STA_ABX: ;
              default: out_nxt.unimplemented = !is_nop(item_r.opcode);
            endcase
            if (taken) pc_nxt = br_target;
          end
          out_nxt.program_counter = pc_nxt;
          out_nxt.accumulator     = a_nxt;
          out_nxt.index_x         = x_nxt;
          out_nxt.stack_pointer   = sp_nxt;
          out_nxt.status_byte     = p_nxt;
          out_valid_nxt           = 1'b1;
          state_nxt               = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= 3'd0;
      a_r         <= 8'd0;
      x_r         <= 8'd0;
      sp_r        <= SP_RESET;
      p_r         <= P_RESET;
      pc_r        <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      a_r         <= a_nxt;
      x_r         <= x_nxt;
      sp_r        <= sp_nxt;
      p_r         <= p_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rdat_r   <= rdat_nxt;
    vec_lo_r <= vec_lo_nxt;
    out_r    <= out_nxt;
    if (accept) begin
      item_r <= in_data;
      // indexed modes add X; memory commands use their own address
      if (in_data.command != CMD_EXEC) begin
        addr_r <= in_data.mem_address;
      end else if (in_data.opcode == OP_LDA_ABX || in_data.opcode == OP_STA_ABX ||
                   in_data.opcode == OP_CMP_ABX) begin
        addr_r <= abs_addr + {8'd0, x_r};
      end else begin
        addr_r <= abs_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_idx] <= mem_wd;
    mem_q_r <= mem_r[mem_idx];
  end

endmodule

// ===== design/c6502x_checker.sv =====
// c6502x_checker: port-level checks on the 6502 subset executor, bound to its top level
// depends on c6502x_pkg and cpu6502_subset_executor_core
module c6502x_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input c6502x_pkg::in_word_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input c6502x_pkg::out_word_t out_data
);
  import c6502x_pkg::*;

  // a word waiting on the output holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output word shown straight after reset");

  // bit 5 is fixed and nothing in the subset clears interrupt disable
  a_p_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status_byte[5] && out_data.status_byte[P_I])
    else $error("status byte lost bit 5 or interrupt disable");

  a_flag_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.unimplemented |-> out_data.read_data == 8'd0)
    else $error("read data on an executed instruction");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status_byte[P_N] |-> !out_data.status_byte[P_Z])
    else $error("negative and zero both set");

endmodule

bind cpu6502_subset_executor_core c6502x_checker u_c6502x_checker (.*);

// ===== tb/c6502x_mirror_pkg.sv =====
`timescale 1ns / 1ps
// c6502x_mirror_pkg: register and memory mirror of the 6502 subset executor, with the
// queue of expected output words and their field checks; depends on c6502x_pkg
package c6502x_mirror_pkg;
  import c6502x_pkg::*;

  class cpu_mirror;
    logic [7:0]  mem_image [logic [15:0]];
    logic [15:0] written_addrs [$];
    logic [7:0]  acc;
    logic [7:0]  idx;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [15:0] pc;
    out_word_t   expected_regs [$];
    int errors;
    int checked;
    int n_exec;
    int n_brk;
    int n_jsr;
    int n_unimpl;
    int n_taken;
    int n_wr;
    int n_rd;

    function new();
      acc   = 8'h00;
      idx   = 8'h00;
      sp    = SP_RESET;
      flags = P_RESET;
      pc    = 16'h0000;
    endfunction

    function void poke(logic [15:0] addr, logic [7:0] data);
      if (!mem_image.exists(addr)) begin
        written_addrs.push_back(addr);
      end
      mem_image[addr] = data;
    endfunction

    function logic [7:0] peek(logic [15:0] addr);
      if (!mem_image.exists(addr)) begin
        $error("stimulus reads unwritten byte at 0x%04h", addr);
        errors++;
        return 8'h00;
      end
      return mem_image[addr];
    endfunction

    function void push_stack(logic [7:0] data);
      poke({STACK_PAGE, sp}, data);
      sp = sp - 8'd1;
    endfunction

    function void update_nz(logic [7:0] v);
      flags[P_N] = v[7];
      flags[P_Z] = (v == 8'h00);
    endfunction

    function bit is_plain_nop(logic [7:0] op);
      return op inside {8'h04, 8'h0C, 8'h14, 8'h1A, 8'h1C, 8'h34, 8'h3A, 8'h3C, 8'h44,
                        8'h54, 8'h5A, 8'h5C, 8'h64, 8'h74, 8'h7A, 8'h7C, 8'h80, 8'h82,
                        8'h89, 8'hC2, 8'hD4, 8'hDA, 8'hDC, 8'hE2, 8'hEA, 8'hF4, 8'hFA,
                        8'hFC};
    endfunction

    // relative branch: offset is sign extended, target wraps at 64k
    function logic [15:0] take_branch(logic [15:0] nxt, logic [7:0] off);
      n_taken++;
      return nxt + {{8{off[7]}}, off};
    endfunction

    // works out the registers after one accepted input word and queues them
    function void take_word(in_word_t w);
      out_word_t   r;
      logic [15:0] abs_a;
      logic [15:0] idx_a;
      logic [15:0] ret;
      logic [15:0] nxt;
      logic [7:0]  m;
      logic [7:0]  diff;
      abs_a = {w.operand_high, w.operand_low};
      idx_a = abs_a + {8'h00, idx};
      r = '0;
      case (w.command)
        CMD_WR: begin
          poke(w.mem_address, w.mem_data);
          n_wr++;
        end
        CMD_RD: begin
          r.read_data = peek(w.mem_address);
          n_rd++;
        end
        CMD_EXEC: begin
          n_exec++;
          nxt = w.next_address;
          case (w.opcode)
            OP_BRK: begin
              ret = w.next_address + 16'd1;
              push_stack(ret[15:8]);
              push_stack(ret[7:0]);
              push_stack(flags | P_PUSH_SET);
              flags[P_B] = 1'b1;
              flags[P_I] = 1'b1;
              nxt = {peek(VEC_BRK + 16'd1), peek(VEC_BRK)};
              n_brk++;
            end
            OP_LDA_IMM: begin
              acc = w.operand_low;
              update_nz(acc);
            end
            OP_LDA_ABS: begin
              acc = peek(abs_a);
              update_nz(acc);
            end
            OP_LDA_ABX: begin
              acc = peek(idx_a);
              update_nz(acc);
            end
            OP_STA_ABS: poke(abs_a, acc);
            OP_STA_ABX: poke(idx_a, acc);
            OP_LDX_IMM: begin
              idx = w.operand_low;
              update_nz(idx);
            end
            OP_TXS: sp = idx;
            OP_TXA: begin
              acc = idx;
              update_nz(acc);
            end
            OP_INX: begin
              idx = idx + 8'd1;
              update_nz(idx);
            end
            OP_DEX: begin
              idx = idx - 8'd1;
              update_nz(idx);
            end
            OP_CMP_ABX: begin
              m = peek(idx_a);
              diff = acc - m;
              update_nz(diff);
              flags[P_C] = (acc >= m);
            end
            OP_BPL: if (!flags[P_N]) nxt = take_branch(w.next_address, w.operand_low);
            OP_BMI: if (flags[P_N]) nxt = take_branch(w.next_address, w.operand_low);
            OP_BNE: if (!flags[P_Z]) nxt = take_branch(w.next_address, w.operand_low);
            OP_JSR: begin
              ret = w.next_address - 16'd1;
              push_stack(ret[15:8]);
              push_stack(ret[7:0]);
              nxt = abs_a;
              n_jsr++;
            end
            OP_SEI: flags[P_I] = 1'b1;
            OP_CLD: flags[P_D] = 1'b0;
            default: begin
              if (!is_plain_nop(w.opcode)) begin
                r.unimplemented = 1'b1;
                n_unimpl++;
              end
            end
          endcase
          pc = nxt;
        end
        default: ;
      endcase
      r.program_counter = pc;
      r.accumulator     = acc;
      r.index_x         = idx;
      r.stack_pointer   = sp;
      r.status_byte     = flags;
      expected_regs.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_regs.size() == 0) begin
        $error("output word 0x%0h with nothing expected", got);
        errors++;
        return;
      end
      want = expected_regs.pop_front();
      checked++;
      check_field("program_counter", want.program_counter, got.program_counter);
      check_field("accumulator", {8'h00, want.accumulator}, {8'h00, got.accumulator});
      check_field("index_x", {8'h00, want.index_x}, {8'h00, got.index_x});
      check_field("stack_pointer", {8'h00, want.stack_pointer}, {8'h00, got.stack_pointer});
      check_field("status_byte", {8'h00, want.status_byte}, {8'h00, got.status_byte});
      check_field("read_data", {8'h00, want.read_data}, {8'h00, got.read_data});
      check_field("unimplemented", {15'h0000, want.unimplemented},
                  {15'h0000, got.unimplemented});
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives cpu6502_subset_executor_core with directed and random command words
// and checks every output word against cpu_mirror; depends on c6502x_pkg, c6502x_mirror_pkg
module testbench;
  import c6502x_pkg::*;
  import c6502x_mirror_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         WATCHDOG     = 500000;
  localparam int         PHASE_WORDS  = 238;
  localparam logic [7:0] KNOWN_OPS [18] = '{
    OP_BRK, OP_LDA_IMM, OP_LDA_ABS, OP_LDA_ABX, OP_STA_ABS, OP_STA_ABX, OP_LDX_IMM,
    OP_TXS, OP_TXA, OP_INX, OP_DEX, OP_CMP_ABX, OP_BPL, OP_BMI, OP_BNE, OP_JSR,
    OP_SEI, OP_CLD
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  cpu_mirror sb;
  in_word_t  cmp_followups [$];
  bit        sender_gaps_on;
  bit        receiver_stalls_on;
  int        ready_left;
  int        ready_pick;
  int        cycle_count;

  cpu6502_subset_executor_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // output side: ready in random stretches, mostly short stalls with a few long ones
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_pick = $urandom_range(0, 99);
      if (!receiver_stalls_on || ready_pick < 60) begin
        out_ready <= 1'b1;
        ready_left = $urandom_range(1, 12);
      end else if (ready_pick < 93) begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(1, 3);
      end else begin
        out_ready <= 1'b0;
        ready_left = $urandom_range(10, 40);
      end
    end else begin
      ready_left = ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] instr_len(logic [7:0] op);
    case (op)
      OP_LDA_IMM, OP_LDX_IMM, OP_BPL, OP_BMI, OP_BNE: return 16'd2;
      OP_LDA_ABS, OP_LDA_ABX, OP_STA_ABS, OP_STA_ABX, OP_CMP_ABX, OP_JSR: return 16'd3;
      default: return 16'd1;
    endcase
  endfunction

  function automatic in_word_t mk_exec(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                                       logic [15:0] nxt);
    in_word_t w;
    w = '0;
    w.command      = CMD_EXEC;
    w.opcode       = op;
    w.operand_low  = lo;
    w.operand_high = hi;
    w.next_address = nxt;
    return w;
  endfunction

  function automatic in_word_t mk_mem(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data);
    in_word_t w;
    w = '0;
    w.command     = cmd;
    w.mem_address = addr;
    w.mem_data    = data;
    return w;
  endfunction

  function automatic logic [15:0] pick_written();
    return sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)];
  endfunction

  // mostly well-formed instructions with the fetcher's next address following on,
  // loads and compares only from bytes already written
  function automatic in_word_t random_word();
    in_word_t    w;
    int          sel;
    logic [15:0] addr;
    if (cmp_followups.size() != 0) return cmp_followups.pop_front();
    w.command      = CMD_EXEC;
    w.opcode       = 8'($urandom_range(0, 255));
    w.operand_low  = 8'($urandom_range(0, 255));
    w.operand_high = 8'($urandom_range(0, 255));
    w.next_address = 16'($urandom_range(0, 65535));
    w.mem_address  = 16'($urandom_range(0, 65535));
    w.mem_data     = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      w.command = CMD_UNUSED;
    end else if (sel < 15) begin
      w.command = CMD_WR;
    end else if (sel < 27) begin
      w.command     = CMD_RD;
      w.mem_address = pick_written();
    end else if (sel < 31) begin
      // store then compare the same byte, so equal compares come up
      addr = 16'($urandom_range(0, 65535));
      w = mk_exec(OP_STA_ABS, addr[7:0], addr[15:8], sb.pc + 16'd3);
      addr = addr - {8'h00, sb.idx};
      cmp_followups.push_back(mk_exec(OP_CMP_ABX, addr[7:0], addr[15:8], sb.pc + 16'd6));
    end else begin
      if ($urandom_range(0, 99) < 80) w.opcode = KNOWN_OPS[$urandom_range(0, 17)];
      case (w.opcode)
        OP_LDA_ABS: {w.operand_high, w.operand_low} = pick_written();
        OP_LDA_ABX, OP_CMP_ABX:
          {w.operand_high, w.operand_low} = pick_written() - {8'h00, sb.idx};
        default: ;
      endcase
      if ($urandom_range(0, 99) < 70) w.next_address = sb.pc + instr_len(w.opcode);
    end
    return w;
  endfunction

  // valid stays high from one word to the next when there is no gap
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.take_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_regs.size() != 0) @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < WATCHDOG) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles, %0d words outstanding", cycle_count,
             sb.expected_regs.size());
    $display("cpu6502_subset_executor_core verification failed");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_data            <= '0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: brk vector first, then every instruction at its edges
    send_word(mk_mem(CMD_WR, VEC_BRK, 8'h00));
    send_word(mk_mem(CMD_WR, 16'hFFFF, 8'hC0));
    send_word(mk_mem(CMD_WR, 16'h80FF, 8'h80));
    send_word(mk_mem(CMD_RD, 16'hFFFF, 8'hFF));
    send_word(mk_exec(OP_LDA_IMM, 8'h00, 8'h00, 16'h0002));
    send_word(mk_exec(OP_LDA_IMM, 8'hFF, 8'hFF, 16'h0004));
    send_word(mk_exec(OP_LDX_IMM, 8'h01, 8'h00, 16'h0006));
    send_word(mk_exec(OP_LDA_ABS, 8'hFF, 8'h80, 16'h0009));
    send_word(mk_exec(OP_LDA_ABX, 8'hFE, 8'h80, 16'h000C));
    send_word(mk_exec(OP_LDX_IMM, 8'hFF, 8'h00, 16'h000E));
    // indexed store that wraps past 0xFFFF, then an indexed compare of 0xFFFF
    send_word(mk_exec(OP_STA_ABX, 8'h01, 8'hFF, 16'h0011));
    send_word(mk_exec(OP_CMP_ABX, 8'h00, 8'hFF, 16'h0014));
    send_word(mk_exec(OP_INX, 8'h00, 8'h00, 16'h0015));
    send_word(mk_exec(OP_DEX, 8'h00, 8'h00, 16'h0016));
    send_word(mk_exec(OP_BMI, 8'h80, 8'h00, 16'h0010));
    send_word(mk_exec(OP_BPL, 8'h7F, 8'h00, 16'hFF92));
    send_word(mk_exec(OP_BNE, 8'h7F, 8'h00, 16'hFFF0));
    send_word(mk_exec(OP_LDX_IMM, 8'h01, 8'h00, 16'h0071));
    // stack pointer wraps below the bottom of page one
    send_word(mk_exec(OP_TXS, 8'h00, 8'h00, 16'h0072));
    send_word(mk_exec(OP_JSR, 8'hFF, 8'hFF, 16'h0000));
    send_word(mk_exec(OP_TXA, 8'h00, 8'h00, 16'h0000));
    send_word(mk_exec(OP_STA_ABS, 8'h34, 8'h12, 16'h0003));
    send_word(mk_exec(OP_SEI, 8'h00, 8'h00, 16'h0004));
    send_word(mk_exec(OP_CLD, 8'h00, 8'h00, 16'h0005));
    send_word(mk_exec(8'hEA, 8'h00, 8'h00, 16'h0006));
    send_word(mk_exec(8'h02, 8'hFF, 8'hFF, 16'h0007));
    send_word(mk_mem(CMD_UNUSED, 16'hFFFF, 8'hFF));
    send_word(mk_exec(OP_BRK, 8'h00, 8'h00, 16'hFFFF));

    // random phases, each opened only once the block has drained
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      sender_gaps_on     = (phase == 0 || phase == 2);
      receiver_stalls_on = (phase < 2);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        send_word(random_word());
      end
    end
    while (cmp_followups.size() != 0) send_word(random_word());

    wait_drained();
    repeat (16) @(posedge clk);
    $display("ran %0d instructions (%0d brk, %0d jsr, %0d unlisted), %0d branches taken",
             sb.n_exec, sb.n_brk, sb.n_jsr, sb.n_unimpl, sb.n_taken);
    $display("%0d memory writes, %0d reads over %0d bytes; %0d output words compared",
             sb.n_wr, sb.n_rd, sb.mem_image.num(), sb.checked);
    if (sb.errors == 0) begin
      $display("cpu6502_subset_executor_core verification clean");
    end else begin
      $display("cpu6502_subset_executor_core verification failed");
    end
    $finish;
  end

endmodule
